FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define KLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keystroke editor check failed");

// Same-cycle implication checked outside reset.
`define KLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keystroke editor check failed");

`endif

FILE: src/kle_pkg.sv
// Shared types, key codes and helpers of the keystroke line editor.
// Used by every module of the block but kle_ram; depends on nothing.
package kle_pkg;

    localparam int LINE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int LIMIT_W        = 7;
    localparam int POS_W          = 6;
    localparam int EV_W           = 3;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [7:0] KEY_CTRL_A    = 8'd1;
    localparam logic [7:0] KEY_CTRL_B    = 8'd2;
    localparam logic [7:0] KEY_CTRL_C    = 8'd3;
    localparam logic [7:0] KEY_CTRL_D    = 8'd4;
    localparam logic [7:0] KEY_CTRL_E    = 8'd5;
    localparam logic [7:0] KEY_CTRL_F    = 8'd6;
    localparam logic [7:0] KEY_CTRL_H    = 8'd8;
    localparam logic [7:0] KEY_TAB       = 8'd9;
    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_CTRL_K    = 8'd11;
    localparam logic [7:0] KEY_CTRL_L    = 8'd12;
    localparam logic [7:0] KEY_RETURN    = 8'd13;
    localparam logic [7:0] KEY_CTRL_N    = 8'd14;
    localparam logic [7:0] KEY_CTRL_P    = 8'd16;
    localparam logic [7:0] KEY_CTRL_T    = 8'd20;
    localparam logic [7:0] KEY_CTRL_U    = 8'd21;
    localparam logic [7:0] KEY_CTRL_W    = 8'd23;
    localparam logic [7:0] KEY_CTRL_Z    = 8'd26;
    localparam logic [7:0] KEY_ESC       = 8'd27;
    localparam logic [7:0] KEY_BRACKET   = 8'd91;
    localparam logic [7:0] KEY_UPPER_C   = 8'd67;
    localparam logic [7:0] KEY_UPPER_D   = 8'd68;
    localparam logic [7:0] KEY_BACKSPACE = 8'd127;
    localparam logic [7:0] BYTE_SPACE    = 8'd32;
    localparam logic [7:0] BYTE_NUL      = 8'd0;

    typedef enum logic [EV_W-1:0] {
        EV_STATUS = 3'd0,
        EV_BYTE   = 3'd1,
        EV_EOF    = 3'd2,
        EV_INTR   = 3'd3,
        EV_SUSP   = 3'd4,
        EV_CR     = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        OP_STATUS,
        OP_CLEAR,
        OP_HOME,
        OP_END,
        OP_RIGHT,
        OP_LEFT,
        OP_DEL,
        OP_INS,
        OP_TAB,
        OP_NL
    } t_op;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_GOT,
        ESC_BRK,
        ESC_SKIP
    } t_esc;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SHIFT_R,
        B_SHIFT_L,
        B_PUT,
        B_NL_GO,
        B_EMIT_RD,
        B_EMIT_LD,
        B_STATUS
    } t_bstate;

    typedef struct packed {
        t_op        op;
        t_event     ev;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qlink;

    // line terminator, written CR, LF, NUL as the count runs down
    function automatic logic [7:0] tail_byte(input logic [1:0] left);
        logic [7:0] b;
        unique case (left)
            2'd3:    b = KEY_RETURN;
            2'd2:    b = KEY_NEWLINE;
            default: b = BYTE_NUL;
        endcase
        return b;
    endfunction

endpackage

FILE: src/keystroke_line_editor_top.sv
// Keystroke line editor: top level joining front end, command queue and back end.
// Depends on kle_pkg, kle_front, kle_cmd_queue and kle_back.
//
// Input channel: one key byte per word on i_key, taken when i_in_valid is high
// and o_in_stall is low. Output channel: result words (event, data byte,
// cursor, length, last) shown on o_out_valid and taken when i_out_stall is low.
// Configuration: i_cfg_we writes i_cfg_data into the buffer limit register.
// The front end classifies a key in the cycle it is taken and queues a command;
// up to two commands wait, then o_in_stall rises until the back end pops one.
// A status key or a delete at column 0 goes straight to the result. Any other
// delete, and an insert that fits under the limit, first shifts the bytes from the
// cursor to the line end through the line RAM, which moves one byte a cycle. A
// newline appends CR LF NUL when they fit under the limit, then emits each byte of
// the line as its own word, the last one flagged by o_last.
// A stalled result holds in the output register and the back end waits on it.
// Reset clears cursor, length, escape state, queue and output valid, and sets
// the limit to 64; line RAM contents stay undefined until written.
module keystroke_line_editor_top #(
    parameter int LINE_DEPTH = kle_pkg::LINE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_key,
    input  logic                        i_cfg_we,
    input  logic [kle_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [kle_pkg::EV_W-1:0]    o_event_res,
    output logic [7:0]                  o_data_byte,
    output logic [kle_pkg::POS_W-1:0]   o_cursor,
    output logic [kle_pkg::POS_W-1:0]   o_line_length,
    output logic                        o_last
);

    logic [kle_pkg::LIMIT_W-1:0] r_limit;
    kle_pkg::t_qlink             push;
    kle_pkg::t_qlink             head;
    logic                        q_full;
    logic                        pop;
    logic                        in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= kle_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    kle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_key    (i_key),
        .o_push   (push)
    );

    kle_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    kle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limit       (r_limit),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_res   (o_event_res),
        .o_data_byte   (o_data_byte),
        .o_cursor      (o_cursor),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

endmodule

FILE: src/kle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/kle_front.sv
// Front end: classifies each key word into an editor command, tracks ESC sequences.
// Depends on kle_pkg.
module kle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_key,
    output kle_pkg::t_qlink o_push
);

    kle_pkg::t_esc r_esc;
    kle_pkg::t_esc n_esc;
    kle_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= kle_pkg::ESC_IDLE;
        end else if (i_accept) begin
            r_esc <= n_esc;
        end
    end

    always_comb begin
        n_esc    = r_esc;
        cmd.op   = kle_pkg::OP_STATUS;
        cmd.ev   = kle_pkg::EV_STATUS;
        cmd.data = i_key;
        unique case (r_esc)
            kle_pkg::ESC_GOT: begin
                n_esc = (i_key == kle_pkg::KEY_BRACKET) ? kle_pkg::ESC_BRK : kle_pkg::ESC_SKIP;
            end
            kle_pkg::ESC_BRK: begin
                n_esc = kle_pkg::ESC_IDLE;
                if (i_key == kle_pkg::KEY_UPPER_C) begin
                    cmd.op = kle_pkg::OP_RIGHT;
                end else if (i_key == kle_pkg::KEY_UPPER_D) begin
                    cmd.op = kle_pkg::OP_LEFT;
                end
            end
            kle_pkg::ESC_SKIP: begin
                n_esc = kle_pkg::ESC_IDLE;
            end
            kle_pkg::ESC_IDLE: begin
                unique case (i_key) inside
                    kle_pkg::KEY_TAB:     cmd.op = kle_pkg::OP_TAB;
                    kle_pkg::KEY_RETURN:  cmd.ev = kle_pkg::EV_CR;
                    kle_pkg::KEY_NEWLINE: cmd.op = kle_pkg::OP_NL;
                    kle_pkg::KEY_BACKSPACE, kle_pkg::KEY_CTRL_H: cmd.op = kle_pkg::OP_DEL;
                    kle_pkg::KEY_CTRL_D: begin
                        cmd.op = kle_pkg::OP_CLEAR;
                        cmd.ev = kle_pkg::EV_EOF;
                    end
                    kle_pkg::KEY_CTRL_C:  cmd.ev = kle_pkg::EV_INTR;
                    kle_pkg::KEY_CTRL_Z:  cmd.ev = kle_pkg::EV_SUSP;
                    kle_pkg::KEY_ESC:     n_esc  = kle_pkg::ESC_GOT;
                    kle_pkg::KEY_CTRL_A:  cmd.op = kle_pkg::OP_HOME;
                    kle_pkg::KEY_CTRL_E:  cmd.op = kle_pkg::OP_END;
                    kle_pkg::KEY_CTRL_F:  cmd.op = kle_pkg::OP_RIGHT;
                    kle_pkg::KEY_CTRL_B:  cmd.op = kle_pkg::OP_LEFT;
                    kle_pkg::KEY_CTRL_K, kle_pkg::KEY_CTRL_L, kle_pkg::KEY_CTRL_N,
                    kle_pkg::KEY_CTRL_P, kle_pkg::KEY_CTRL_T, kle_pkg::KEY_CTRL_U,
                    kle_pkg::KEY_CTRL_W:  cmd.op = kle_pkg::OP_STATUS;
                    default:              cmd.op = kle_pkg::OP_INS;
                endcase
            end
        endcase
    end

    assign o_push.valid = i_accept;
    assign o_push.cmd   = cmd;

endmodule

FILE: src/kle_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on kle_pkg.
module kle_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kle_pkg::t_qlink i_push,
    output logic            o_full,
    output kle_pkg::t_qlink o_head,
    input  logic            i_pop
);

    localparam int QD  = kle_pkg::QUEUE_DEPTH;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW  = $clog2(QD + 1);

    kle_pkg::t_cmd r_mem [QD];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full       = (r_cnt == CW'(QD));
    assign push_ok      = i_push.valid && !o_full;
    assign pop_ok       = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/kle_back.sv
// Back end: executes editor commands on the line store and drives the result register.
// Depends on kle_pkg and kle_ram.
module kle_back #(
    parameter int LINE_DEPTH = kle_pkg::LINE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [kle_pkg::LIMIT_W-1:0]  i_limit,
    input  kle_pkg::t_qlink              i_head,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [kle_pkg::EV_W-1:0]     o_event_res,
    output logic [7:0]                   o_data_byte,
    output logic [kle_pkg::POS_W-1:0]    o_cursor,
    output logic [kle_pkg::POS_W-1:0]    o_line_length,
    output logic                         o_last
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = kle_pkg::LIMIT_W;

    kle_pkg::t_bstate r_state, n_state;
    kle_pkg::t_op     r_kind, n_kind;
    kle_pkg::t_event  r_ev, n_ev;
    logic [7:0]       r_byte, n_byte;
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [AW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    logic [AW-1:0]    r_wr_addr, n_wr_addr;
    logic             r_pend, n_pend;
    logic [1:0]       r_put, n_put;

    logic                  r_o_valid, n_o_valid;
    kle_pkg::t_event       r_o_ev, n_o_ev;
    logic [7:0]            r_o_data, n_o_data;
    logic [AW-1:0]         r_o_cursor, n_o_cursor;
    logic [AW-1:0]         r_o_len, n_o_len;
    logic                  r_o_last, n_o_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [LW-1:0] lim;
    logic [1:0]    ins_n;
    logic          ld_ok;
    logic [7:0]    put_byte;
    logic          emit_last;

    kle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign lim   = (i_limit > LW'(LINE_DEPTH)) ? LW'(LINE_DEPTH) : i_limit;
    assign ins_n = (i_head.cmd.op == kle_pkg::OP_TAB) ? 2'd2 : 2'd1;
    assign ld_ok = !r_o_valid || !i_out_stall;
    assign emit_last = (r_rd_addr == r_cnt - 1'b1);

    always_comb begin
        case (r_kind)
            kle_pkg::OP_NL:  put_byte = kle_pkg::tail_byte(r_put);
            kle_pkg::OP_TAB: put_byte = kle_pkg::BYTE_SPACE;
            default:         put_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kle_pkg::B_IDLE;
            r_cursor  <= '0;
            r_fill    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_fill    <= n_fill;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_ev       <= n_ev;
        r_byte     <= n_byte;
        r_cnt      <= n_cnt;
        r_rd_addr  <= n_rd_addr;
        r_wr_addr  <= n_wr_addr;
        r_put      <= n_put;
        r_o_ev     <= n_o_ev;
        r_o_data   <= n_o_data;
        r_o_cursor <= n_o_cursor;
        r_o_len    <= n_o_len;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_ev       = r_ev;
        n_byte     = r_byte;
        n_cursor   = r_cursor;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_rd_addr  = r_rd_addr;
        n_wr_addr  = r_wr_addr;
        n_pend     = r_pend;
        n_put      = r_put;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_ev     = r_o_ev;
        n_o_data   = r_o_data;
        n_o_cursor = r_o_cursor;
        n_o_len    = r_o_len;
        n_o_last   = r_o_last;
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_wr_addr;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = r_rd_addr;

        unique case (r_state)
            kle_pkg::B_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_kind  = i_head.cmd.op;
                    n_ev    = i_head.cmd.ev;
                    n_byte  = i_head.cmd.data;
                    n_state = kle_pkg::B_STATUS;
                    case (i_head.cmd.op)
                        kle_pkg::OP_CLEAR: begin
                            n_cursor = '0;
                            n_fill   = '0;
                        end
                        kle_pkg::OP_HOME: n_cursor = '0;
                        kle_pkg::OP_END:  n_cursor = r_fill;
                        kle_pkg::OP_RIGHT: begin
                            if (r_cursor < r_fill) begin
                                n_cursor = r_cursor + 1'b1;
                            end
                        end
                        kle_pkg::OP_LEFT: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - 1'b1;
                            end
                        end
                        kle_pkg::OP_DEL: begin
                            if (r_cursor != '0) begin
                                n_cnt     = r_fill - r_cursor;
                                n_rd_addr = r_cursor;
                                n_state   = kle_pkg::B_SHIFT_L;
                            end
                        end
                        kle_pkg::OP_INS, kle_pkg::OP_TAB: begin
                            if ((LW'(r_fill) + LW'(ins_n)) < lim) begin
                                n_cnt     = r_fill - r_cursor;
                                n_rd_addr = r_fill - 1'b1;
                                n_put     = ins_n;
                                n_state   = kle_pkg::B_SHIFT_R;
                            end
                        end
                        kle_pkg::OP_NL: begin
                            n_cursor = r_fill;
                            if ((LW'(r_fill) + LW'(3)) < lim) begin
                                n_put   = 2'd3;
                                n_state = kle_pkg::B_PUT;
                            end else begin
                                n_state = kle_pkg::B_NL_GO;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            kle_pkg::B_SHIFT_R, kle_pkg::B_SHIFT_L: begin
                // read one byte ahead, write the previous one at its new place
                ram_re = (r_cnt != '0);
                ram_we = r_pend;
                if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                    if (r_state == kle_pkg::B_SHIFT_R) begin
                        n_wr_addr = r_rd_addr + AW'(r_put);
                        n_rd_addr = r_rd_addr - 1'b1;
                    end else begin
                        n_wr_addr = r_rd_addr - 1'b1;
                        n_rd_addr = r_rd_addr + 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_state == kle_pkg::B_SHIFT_R) begin
                            n_state = kle_pkg::B_PUT;
                        end else begin
                            n_cursor = r_cursor - 1'b1;
                            n_fill   = r_fill - 1'b1;
                            n_state  = kle_pkg::B_STATUS;
                        end
                    end
                end
            end

            kle_pkg::B_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cursor;
                ram_wdata = put_byte;
                n_cursor  = r_cursor + 1'b1;
                n_fill    = r_fill + 1'b1;
                n_put     = r_put - 1'b1;
                if (r_put == 2'd1) begin
                    n_state = (r_kind == kle_pkg::OP_NL) ? kle_pkg::B_NL_GO : kle_pkg::B_STATUS;
                end
            end

            kle_pkg::B_NL_GO: begin
                n_cnt     = r_fill;
                n_cursor  = '0;
                n_fill    = '0;
                n_rd_addr = '0;
                n_state   = (r_fill == '0) ? kle_pkg::B_STATUS : kle_pkg::B_EMIT_RD;
            end

            kle_pkg::B_EMIT_RD: begin
                ram_re  = 1'b1;
                n_state = kle_pkg::B_EMIT_LD;
            end

            kle_pkg::B_EMIT_LD: begin
                if (ld_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_ev     = kle_pkg::EV_BYTE;
                    n_o_data   = ram_rdata;
                    n_o_cursor = r_cursor;
                    n_o_len    = r_fill;
                    n_o_last   = emit_last;
                    n_rd_addr  = r_rd_addr + 1'b1;
                    n_state    = emit_last ? kle_pkg::B_IDLE : kle_pkg::B_EMIT_RD;
                end
            end

            kle_pkg::B_STATUS: begin
                if (ld_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_ev     = r_ev;
                    n_o_data   = '0;
                    n_o_cursor = r_cursor;
                    n_o_len    = r_fill;
                    n_o_last   = 1'b1;
                    n_state    = kle_pkg::B_IDLE;
                end
            end

            default: n_state = kle_pkg::B_IDLE;
        endcase
    end

    assign o_out_valid   = r_o_valid;
    assign o_event_res   = r_o_ev;
    assign o_data_byte   = r_o_data;
    assign o_cursor      = kle_pkg::POS_W'(r_o_cursor);
    assign o_line_length = kle_pkg::POS_W'(r_o_len);
    assign o_last        = r_o_last;

endmodule

FILE: src/kle_checker.sv
// Port-level checks on the keystroke line editor, bound to the top level.
// Depends on kle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kle_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [kle_pkg::EV_W-1:0]    o_event_res,
    input logic [7:0]                  o_data_byte,
    input logic [kle_pkg::POS_W-1:0]   o_cursor,
    input logic [kle_pkg::POS_W-1:0]   o_line_length,
    input logic                        o_last
);

    logic                                        out_wait;
    logic                                        is_byte;
    logic [kle_pkg::EV_W+8+2*kle_pkg::POS_W:0]   out_word;

    assign out_wait = o_out_valid && i_out_stall;
    assign is_byte  = (o_event_res == kle_pkg::EV_BYTE);
    assign out_word = {o_event_res, o_data_byte, o_cursor, o_line_length, o_last};

    `KLE_ASSERT(a_out_hold, i_clk, i_rst_n, out_wait |=> o_out_valid && $stable(out_word))
    `KLE_ASSERT_IMPL(a_data_zero, i_clk, i_rst_n, o_out_valid && !is_byte, o_data_byte == '0)
    `KLE_ASSERT_IMPL(a_ev_range, i_clk, i_rst_n, o_out_valid, o_event_res <= kle_pkg::EV_CR)
    `KLE_ASSERT_IMPL(a_byte_clear, i_clk, i_rst_n, o_out_valid && is_byte, (o_cursor | o_line_length) == '0)
    `KLE_ASSERT_IMPL(a_cursor_in, i_clk, i_rst_n, o_out_valid, o_cursor <= o_line_length)

endmodule

bind keystroke_line_editor_top kle_checker u_kle_checker (.*);
